FILE: rtl/core/lsb_first_bit_packer_core_defines.svh
// assertion macros for the bit packer
`ifndef LSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH
`define LSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH

// next-cycle implication, off while reset is low
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset too
`define LBP_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/lbp_pkg.sv
package lbp_pkg;

  // widest append and most bytes one word can produce
  localparam int unsigned AppendMax = 32;
  localparam int unsigned MaxBytes  = 5;
  localparam int unsigned AccW      = 8 * MaxBytes;

  // one queued job: packed bytes, lowest byte first, and how many to send
  typedef struct packed {
    logic [AccW-1:0] data;
    logic [2:0]      nbytes;
  } lbp_entry_t;

  // front to queue
  typedef struct packed {
    logic       valid;
    lbp_entry_t entry;
  } lbp_push_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } lbp_fifo_stat_t;

  // low n bits set, all bits for n of 32 or more
  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [31:0] m;
    if (n >= 6'(AppendMax)) begin
      m = '1;
    end else begin
      m = ~(32'hffff_ffff << n[4:0]);
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/lsb_first_bit_packer_core.sv
// LSB-first bit packer. Each input word appends the low in_bit_count bits
// (0 to 32; larger counts append nothing) of in_value above the 0 to 7 bits
// still pending and sends every completed byte, earlier bits in lower
// positions. in_flush also sends the zero-padded partial byte and clears
// the pending bits. The final byte of each input word has out_last set;
// a word that completes no byte sends nothing. The front stage merges a
// word combinationally and takes one word per cycle while the job queue of
// QUEUE_DEPTH entries has room; the back stage sends one byte per cycle,
// while out_stall is low, from its output register. A word that yields n
// bytes (0 to 5) holds the back stage until all n are sent; meanwhile the
// front stage keeps taking words into the queue. When the block is idle, the
// first byte of a word passes the job queue and the output register in turn.
module lsb_first_bit_packer_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_value,
  input  logic [5:0]  in_bit_count,
  input  logic        in_flush,
  output logic        in_stall,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  logic        out_stall
);

  lbp_pkg::lbp_push_t      push;
  lbp_pkg::lbp_entry_t     head;
  lbp_pkg::lbp_fifo_stat_t fifo_stat;
  logic                    pop;

  // merge and classify
  lbp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_value     (in_value),
    .in_bit_count (in_bit_count),
    .in_flush     (in_flush),
    .in_stall     (in_stall),
    .fifo_stat    (fifo_stat),
    .push         (push)
  );

  // job queue
  lbp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (fifo_stat)
  );

  // byte sender
  lbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_stall (out_stall)
  );

endmodule

FILE: rtl/core/lbp_front.sv
module lbp_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [31:0]            in_value,
  input  logic [5:0]             in_bit_count,
  input  logic                   in_flush,
  output logic                   in_stall,
  input  lbp_pkg::lbp_fifo_stat_t fifo_stat,
  output lbp_pkg::lbp_push_t     push
);

  logic [6:0]  pend_bits_r, pend_bits_nxt;
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic        accept;
  logic        append;
  logic [31:0] masked;
  logic [38:0] acc;
  logic [lbp_pkg::AccW-1:0] acc_ext;
  logic [5:0]  total;
  logic [2:0]  full_bytes;
  logic [2:0]  rem_bits;
  logic [2:0]  nbytes;

  assign in_stall = fifo_stat.full;
  assign accept   = in_valid && !in_stall;

  // merge the new bits above the pending ones
  always_comb begin
    append = (in_bit_count <= 6'(lbp_pkg::AppendMax));
    masked = in_value & lbp_pkg::low_mask(in_bit_count);
    acc    = {32'd0, pend_bits_r};
    total  = {3'd0, pend_cnt_r};
    if (append) begin
      acc   = acc | ({7'd0, masked} << pend_cnt_r);
      total = total + in_bit_count;
    end
    acc_ext    = {{(lbp_pkg::AccW-39){1'b0}}, acc};
    full_bytes = total[5:3];
    rem_bits   = total[2:0];
    nbytes     = full_bytes + {2'd0, (in_flush && (rem_bits != 3'd0))};
  end

  // leftover bits stay pending unless flushed
  always_comb begin
    if (in_flush) begin
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
    end else begin
      pend_bits_nxt = acc_ext[{full_bytes, 3'd0} +: 7];
      pend_cnt_nxt  = rem_bits;
    end
  end

  // words that produce no byte are not queued
  always_comb begin
    push.valid        = accept && (nbytes != 3'd0);
    push.entry.data   = acc_ext;
    push.entry.nbytes = nbytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (accept) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/lbp_fifo.sv
module lbp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lbp_pkg::lbp_push_t      push,
  input  logic                    pop,
  output lbp_pkg::lbp_entry_t     head,
  output lbp_pkg::lbp_fifo_stat_t stat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  lbp_pkg::lbp_entry_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (cnt_r == CntW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

FILE: rtl/core/lbp_back.sv
module lbp_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lbp_pkg::lbp_entry_t     head,
  input  lbp_pkg::lbp_fifo_stat_t fifo_stat,
  output logic                    pop,
  output logic                    out_valid,
  output logic [7:0]              out_byte,
  output logic                    out_last,
  input  logic                    out_stall
);

  logic [lbp_pkg::AccW-1:0] cur_data_r, cur_data_nxt;
  logic [2:0]               cur_left_r, cur_left_nxt;
  logic                     cur_valid_r, cur_valid_nxt;
  logic                     taken;
  logic                     load;

  assign out_valid = cur_valid_r;
  assign out_byte  = cur_data_r[7:0];
  assign out_last  = (cur_left_r == 3'd1);
  assign taken     = cur_valid_r && !out_stall;
  assign load      = !cur_valid_r || (taken && out_last);
  assign pop       = load && !fifo_stat.empty;

  // shift out one byte per byte taken, refill from the queue after the last
  always_comb begin
    cur_data_nxt  = cur_data_r;
    cur_left_nxt  = cur_left_r;
    cur_valid_nxt = cur_valid_r;
    if (load) begin
      cur_valid_nxt = !fifo_stat.empty;
      cur_data_nxt  = head.data;
      cur_left_nxt  = head.nbytes;
    end else if (taken) begin
      cur_data_nxt = cur_data_r >> 8;
      cur_left_nxt = cur_left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_left_r  <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cur_left_r  <= cur_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_data_r <= cur_data_nxt;
  end

endmodule

FILE: rtl/core/lbp_checker.sv
`include "lsb_first_bit_packer_core_defines.svh"

module lbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic [31:0] in_value,
  input logic [5:0]  in_bit_count,
  input logic        in_flush,
  input logic        in_stall,
  input logic        out_valid,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic        out_stall
);

  // a stalled byte stays put
  `LBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_last), "stalled output byte changed")

  // a byte that is not the last of its word is followed by another
  `LBP_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !out_last, out_valid, "run of bytes broken before last")

  // reset empties the sender
  `LBP_ASSERT_NEXT_ALWAYS(a_reset_out, !rst_n, !out_valid, "output valid right after reset")

  // reset empties the queue
  `LBP_ASSERT_NEXT_ALWAYS(a_reset_in, !rst_n, !in_stall, "input stalled right after reset")

endmodule

bind lsb_first_bit_packer_core lbp_checker u_lbp_checker (.*);

FILE: test/tb_lsb_first_bit_packer_core.sv
module tb_lsb_first_bit_packer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumDirected   = 24;
  localparam int NumRandom     = 356;
  localparam int QuietTail     = 60;
  localparam int HoldAtWord    = 60;
  localparam int HoldCycles    = 80;
  localparam int DrainCycles   = 20;
  localparam int WatchdogLimit = 2000;
  localparam int MaxPrinted    = 40;

  // one byte we still wait for on the output
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } due_byte_t;

  // one directed word; typed rows carry their bytes, lowest first
  typedef struct packed {
    logic [31:0]          value;
    logic [5:0]           nbits;
    logic                 flush;
    logic                 typed;
    logic [2:0]           nbytes;
    logic [8*lbp_pkg::MaxBytes-1:0] bytes;
  } dir_word_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [31:0] in_value     = '0;
  logic [5:0]  in_bit_count = '0;
  logic        in_flush     = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_stall    = 1'b0;

  // packer state as the block should hold it
  logic [6:0]  pend_bits = '0;
  logic [2:0]  pend_cnt  = '0;

  due_byte_t   byte_due_q[$];
  due_byte_t   due;
  int          err_count  = 0;
  int          idle_count = 0;
  logic        send_idle  = 1'b1;
  logic        recv_idle  = 1'b1;
  logic        hold_req   = 1'b0;

  dir_word_t dir_words [NumDirected] = '{
    // full append right after reset
    '{32'hffff_ffff, 6'd32, 1'b0, 1'b1, 3'd4, 40'h00_ffff_ffff},
    // zero count without flush
    '{32'h0000_0000, 6'd0,  1'b0, 1'b1, 3'd0, 40'h0},
    // flush with nothing pending
    '{32'h0000_0000, 6'd0,  1'b1, 1'b1, 3'd0, 40'h0},
    // oversize counts append nothing
    '{32'hffff_ffff, 6'd63, 1'b0, 1'b1, 3'd0, 40'h0},
    '{32'hffff_ffff, 6'd33, 1'b1, 1'b1, 3'd0, 40'h0},
    // masking leaves three pending bits, oversize flush sends them
    '{32'hffff_fffd, 6'd3,  1'b0, 1'b1, 3'd0, 40'h0},
    '{32'hffff_ffff, 6'd40, 1'b1, 1'b1, 3'd1, 40'h05},
    // seven pending, one more completes the byte
    '{32'hffff_ffff, 6'd7,  1'b0, 1'b1, 3'd0, 40'h0},
    '{32'h0000_0000, 6'd1,  1'b0, 1'b1, 3'd1, 40'h7f},
    // seven pending plus full append and flush: five bytes
    '{32'hffff_ffff, 6'd7,  1'b0, 1'b1, 3'd0, 40'h0},
    '{32'hffff_ffff, 6'd32, 1'b1, 1'b1, 3'd5, 40'h7f_ffff_ffff},
    '{32'hffff_ffff, 6'd8,  1'b1, 1'b1, 3'd1, 40'hff},
    '{32'h0000_0000, 6'd32, 1'b0, 1'b1, 3'd4, 40'h0},
    // mixed rows left to the predictor
    '{32'ha5a5_a5a5, 6'd32, 1'b0, 1'b0, 3'd0, 40'h0},
    '{32'h1234_5678, 6'd13, 1'b0, 1'b0, 3'd0, 40'h0},
    '{32'hdead_beef, 6'd1,  1'b1, 1'b0, 3'd0, 40'h0},
    '{32'h8000_0000, 6'd32, 1'b0, 1'b0, 3'd0, 40'h0},
    '{32'h0000_0001, 6'd1,  1'b0, 1'b0, 3'd0, 40'h0},
    '{32'h0000_0000, 6'd32, 1'b1, 1'b0, 3'd0, 40'h0},
    '{32'h7fff_ffff, 6'd31, 1'b0, 1'b0, 3'd0, 40'h0},
    '{32'h5555_5555, 6'd17, 1'b1, 1'b0, 3'd0, 40'h0},
    '{32'h0000_003c, 6'd6,  1'b0, 1'b0, 3'd0, 40'h0},
    '{32'hffff_ffff, 6'd2,  1'b0, 1'b0, 3'd0, 40'h0},
    '{32'h0000_0000, 6'd7,  1'b1, 1'b0, 3'd0, 40'h0}
  };

  lsb_first_bit_packer_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_value     (in_value),
    .in_bit_count (in_bit_count),
    .in_flush     (in_flush),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_stall    (out_stall)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // append a word to the pending bits, return the bytes it completes
  function automatic int pack_word(input logic [31:0] v, input logic [5:0] n,
                                   input logic f,
                                   output logic [8*lbp_pkg::MaxBytes-1:0] packed_out);
    logic [39:0] acc;
    int          total;
    int          cnt;
    acc        = 40'(pend_bits);
    total      = int'(pend_cnt);
    cnt        = 0;
    packed_out = '0;
    if (n <= 6'(lbp_pkg::AppendMax)) begin
      acc   = acc | ((40'(v) & ((40'd1 << n) - 40'd1)) << total);
      total = total + int'(n);
    end
    while (total >= 8) begin
      packed_out[cnt*8 +: 8] = acc[7:0];
      cnt++;
      acc   = acc >> 8;
      total = total - 8;
    end
    // partial byte goes out zero-padded
    if (f) begin
      if (total > 0) begin
        packed_out[cnt*8 +: 8] = acc[7:0];
        cnt++;
      end
      acc   = '0;
      total = 0;
    end
    pend_cnt  = 3'(total);
    pend_bits = acc[6:0];
    return cnt;
  endfunction

  task automatic flag_error(input string msg);
    if (err_count < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // offer one word, wait for it to be taken, then queue its bytes
  task automatic send_word(input logic [31:0] v, input logic [5:0] n, input logic f,
                           input logic typed, input logic [2:0] typed_cnt,
                           input logic [8*lbp_pkg::MaxBytes-1:0] typed_bytes);
    logic [8*lbp_pkg::MaxBytes-1:0] bytes;
    int                    cnt;
    int                    gap;
    due_byte_t             b;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_value     <= v;
    in_bit_count <= n;
    in_flush     <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cnt = pack_word(v, n, f, bytes);
    if (typed) begin
      cnt   = int'(typed_cnt);
      bytes = typed_bytes;
    end
    for (int i = 0; i < cnt; i++) begin
      b.data = bytes[i*8 +: 8];
      b.last = (i == cnt - 1);
      byte_due_q.push_back(b);
    end
  endtask

  // word source: reset, directed table, random words, drain and verdict
  initial begin
    logic [31:0] v;
    logic [5:0]  n;
    logic        f;
    int          pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_words[i]) begin
      send_word(dir_words[i].value, dir_words[i].nbits, dir_words[i].flush,
                dir_words[i].typed, dir_words[i].nbytes, dir_words[i].bytes);
    end
    for (int idx = 0; idx < NumRandom; idx++) begin
      if (idx % 50 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      if (idx == HoldAtWord) begin
        hold_req = 1'b1;
      end
      if (idx >= NumRandom - QuietTail) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      // mostly legal counts, full words often, some oversize
      pick = $urandom_range(0, 9);
      case (pick)
        0:       n = 6'($urandom_range(33, 63));
        1:       n = 6'd0;
        2, 3, 4: n = 6'd32;
        default: n = 6'($urandom_range(1, 31));
      endcase
      v = $urandom;
      f = ($urandom_range(0, 4) == 0);
      send_word(v, n, f, 1'b0, 3'd0, '0);
    end
    in_valid <= 1'b0;
    while (byte_due_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("lsb_first_bit_packer_core verification clean");
    end else begin
      $display("lsb_first_bit_packer_core verification failed");
    end
    $finish;
  end

  // byte sink: random stall bursts, one long hold to back up the queue
  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // check each byte taken, watch for a hang
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (byte_due_q.size() == 0) begin
        flag_error($sformatf("byte %02h last %0b with nothing due", out_byte, out_last));
      end else begin
        due = byte_due_q.pop_front();
        if (out_byte !== due.data) begin
          flag_error($sformatf("byte got %02h want %02h", out_byte, due.data));
        end
        if (out_last !== due.last) begin
          flag_error($sformatf("last got %0b want %0b on byte %02h",
                               out_last, due.last, due.data));
        end
      end
    end
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_count = 0;
    end else begin
      idle_count++;
    end
    if (idle_count >= WatchdogLimit) begin
      $display("lsb_first_bit_packer_core verification failed");
      $finish;
    end
  end

endmodule
